// ===== src/dewc_pkg.sv =====
// shared types, constants and helper functions of the event window classifier
package dewc_pkg;

  localparam int CHANNELS      = 40;
  localparam int SPECTRUM_BINS = 8000;
  localparam int FRACTION_BITS = 4;

  localparam int MULT_W   = 6;
  localparam int CHAN_W   = 6;
  localparam int ENERGY_W = 18;
  localparam int DS_W     = 4;
  localparam int HIST_W   = 5;
  localparam int BIN_W    = 13;
  localparam int SUM_W    = ENERGY_W + 1;
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_APPLY_VETO    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INCLUDE_NAT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAIRS_ENABLED = 2'd2;

  // dataset codes
  localparam logic [DS_W-1:0] DS_EXCLUDED = 4'hF;
  localparam logic [DS_W-1:0] DS_BEGE_A   = 4'd0;
  localparam logic [DS_W-1:0] DS_ENR_COAX = 4'd1;
  localparam logic [DS_W-1:0] DS_NAT_COAX = 4'd3;
  localparam logic [DS_W-1:0] DS_BEGE_B   = 4'd4;

  // histogram targets
  localparam logic [HIST_W-1:0] H_CHAN_SPEC  = 5'd0;
  localparam logic [HIST_W-1:0] H_BEGE_SPEC  = 5'd1;
  localparam logic [HIST_W-1:0] H_COAX_SPEC  = 5'd2;
  localparam logic [HIST_W-1:0] H_NAT_SPEC   = 5'd3;
  localparam logic [HIST_W-1:0] H_WIN_SINGLE = 5'd4;
  localparam logic [HIST_W-1:0] H_PAIR_2D    = 5'd10;
  localparam logic [HIST_W-1:0] H_PAIR_SUM   = 5'd11;
  localparam logic [HIST_W-1:0] H_PAIR_E     = 5'd12;
  localparam logic [HIST_W-1:0] H_PAIR_CC    = 5'd13;
  localparam logic [HIST_W-1:0] H_PAIR_CH    = 5'd19;

  localparam int WINDOWS = 6;
  localparam int MARKER_KEV = 10000;

  // window bounds in keV, [lo, hi)
  localparam logic [31:0] SINGLE_LO [WINDOWS] = '{32'd1521, 32'd1457, 32'd565,
                                                  32'd1405, 32'd1470, 32'd1535};
  localparam logic [31:0] SINGLE_HI [WINDOWS] = '{32'd1529, 32'd1465, 32'd5500,
                                                  32'd1450, 32'd1515, 32'd1580};
  localparam logic [31:0] PAIR_LO [WINDOWS]   = '{32'd1519, 32'd1455, 32'd250,
                                                  32'd1405, 32'd1470, 32'd1535};
  localparam logic [31:0] PAIR_HI [WINDOWS]   = '{32'd1531, 32'd1467, 32'd3000,
                                                  32'd1450, 32'd1515, 32'd1580};

  // fill slots of one job: pair jobs use four fixed fills and three per window
  localparam int PAIR_FIXED = 4;
  localparam int SLOTS      = PAIR_FIXED + 3 * WINDOWS;
  localparam int SLOT_W     = $clog2(SLOTS);
  localparam int SGL_WIN0   = 2;

  localparam int JOBQ_DEPTH = 2;
  localparam int JOBQ_PTR_W = (JOBQ_DEPTH > 1) ? $clog2(JOBQ_DEPTH) : 1;
  localparam int JOBQ_CNT_W = $clog2(JOBQ_DEPTH + 1);

  typedef logic [SLOTS-1:0] slot_mask_t;

  typedef struct packed {
    logic apply_veto;
    logic include_natural_coax;
    logic pairs_enabled;
  } cfg_t;

  typedef struct packed {
    logic              pair;
    logic [HIST_W-1:0] ds_hist;
    logic [CHAN_W-1:0] c1;
    logic [CHAN_W-1:0] c2;
    logic [BIN_W-1:0]  bin1;
    logic [BIN_W-1:0]  bin2;
    logic [BIN_W-1:0]  bin3;
  } fill_ctx_t;

  typedef struct packed {
    fill_ctx_t  ctx;
    slot_mask_t mask;
  } job_t;

  function automatic logic [31:0] kev(input logic [31:0] k);
    return k << FRACTION_BITS;
  endfunction

  function automatic logic [BIN_W-1:0] bin_of(input logic [SUM_W-1:0] e);
    logic [31:0] b;
    b = 32'(e) >> FRACTION_BITS;
    if (b >= 32'(SPECTRUM_BINS)) begin
      b = 32'(SPECTRUM_BINS);
    end
    return b[BIN_W-1:0];
  endfunction

  function automatic logic ds_ok(input logic [DS_W-1:0] d, input logic nat);
    return (d == DS_BEGE_A) || (d == DS_ENR_COAX) || (d == DS_BEGE_B) ||
           ((d == DS_NAT_COAX) && nat);
  endfunction

endpackage

// ===== src/dewc_front.sv =====
// front part: holds the pair hits and turns each item into a fill job
module dewc_front import dewc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  cfg_t                cfg,
  input  logic                accept,
  input  logic [MULT_W-1:0]   multiplicity,
  input  logic                vetoed,
  input  logic [CHAN_W-1:0]   channel,
  input  logic [ENERGY_W-1:0] energy,
  input  logic [DS_W-1:0]     dataset,
  input  logic                last_channel,
  output logic                job_valid,
  output job_t                job
);

  logic [1:0]          hit_count;
  logic [CHAN_W-1:0]   first_hit_channel;
  logic [ENERGY_W-1:0] first_hit_energy;
  logic [DS_W-1:0]     first_hit_dataset;
  logic [CHAN_W-1:0]   second_hit_channel;
  logic [ENERGY_W-1:0] second_hit_energy;
  logic [DS_W-1:0]     second_hit_dataset;

  logic                live;
  logic                single_path;
  logic                pair_path;
  logic                counted;
  logic [1:0]          hit_count_next;
  logic [31:0]         e32;
  logic                single_ok;
  logic                ds_known;
  logic [HIST_W-1:0]   ds_hist;
  logic [WINDOWS-1:0]  swin;
  slot_mask_t          single_mask;

  logic [CHAN_W-1:0]   a_ch;
  logic [ENERGY_W-1:0] a_e;
  logic [DS_W-1:0]     a_ds;
  logic [CHAN_W-1:0]   b_ch;
  logic [ENERGY_W-1:0] b_e;
  logic [DS_W-1:0]     b_ds;
  logic                swap;
  logic [CHAN_W-1:0]   p1_ch;
  logic [CHAN_W-1:0]   p2_ch;
  logic [ENERGY_W-1:0] p1_e;
  logic [ENERGY_W-1:0] p2_e;
  logic [SUM_W-1:0]    psum;
  logic                pair_ok;
  logic [WINDOWS-1:0]  pwin;
  slot_mask_t          pair_mask;

  assign live = !(cfg.apply_veto && vetoed) &&
                ({1'b0, channel} < (CHAN_W + 1)'(CHANNELS));
  assign single_path = live && (multiplicity == MULT_W'(1));
  assign pair_path   = live && (multiplicity == MULT_W'(2)) && cfg.pairs_enabled;
  assign counted     = (dataset != DS_EXCLUDED) && (energy != '0);
  assign hit_count_next = (counted && hit_count != 2'd3) ? hit_count + 2'd1 : hit_count;

  // single-hit fills
  assign e32 = 32'(energy);
  assign single_ok = (dataset != DS_EXCLUDED) && (energy != '0) &&
                     (e32 < kev(32'(MARKER_KEV)));

  always_comb begin
    ds_known = 1'b1;
    ds_hist  = H_BEGE_SPEC;
    unique case (dataset)
      DS_BEGE_A, DS_BEGE_B: ds_hist = H_BEGE_SPEC;
      DS_ENR_COAX:          ds_hist = H_COAX_SPEC;
      DS_NAT_COAX:          ds_hist = H_NAT_SPEC;
      default:              ds_known = 1'b0;
    endcase
  end

  always_comb begin
    for (int w = 0; w < WINDOWS; w++) begin
      swin[w] = (e32 >= kev(SINGLE_LO[w])) && (e32 < kev(SINGLE_HI[w]));
    end
    single_mask = '0;
    single_mask[0] = 1'b1;
    single_mask[1] = ds_known;
    single_mask[SGL_WIN0 +: WINDOWS] = swin;
  end

  // pair as it stands once this item's hit is counted
  always_comb begin
    a_ch = first_hit_channel;
    a_e  = first_hit_energy;
    a_ds = first_hit_dataset;
    b_ch = second_hit_channel;
    b_e  = second_hit_energy;
    b_ds = second_hit_dataset;
    if (counted && hit_count == 2'd0) begin
      a_ch = channel;
      a_e  = energy;
      a_ds = dataset;
    end
    if (counted && hit_count == 2'd1) begin
      b_ch = channel;
      b_e  = energy;
      b_ds = dataset;
    end
  end

  assign swap  = b_ch < a_ch;
  assign p1_ch = swap ? b_ch : a_ch;
  assign p2_ch = swap ? a_ch : b_ch;
  assign p1_e  = swap ? b_e : a_e;
  assign p2_e  = swap ? a_e : b_e;
  assign psum  = SUM_W'(p1_e) + SUM_W'(p2_e);

  assign pair_ok = (hit_count_next == 2'd2) &&
                   (32'(p1_e) != kev(32'(MARKER_KEV))) &&
                   (32'(p2_e) != kev(32'(MARKER_KEV))) &&
                   ds_ok(a_ds, cfg.include_natural_coax) &&
                   ds_ok(b_ds, cfg.include_natural_coax);

  always_comb begin
    for (int w = 0; w < WINDOWS; w++) begin
      pwin[w] = (32'(psum) >= kev(PAIR_LO[w])) && (32'(psum) < kev(PAIR_HI[w]));
    end
    pair_mask = '0;
    pair_mask[PAIR_FIXED-1:0] = '1;
    for (int w = 0; w < WINDOWS; w++) begin
      pair_mask[PAIR_FIXED + 3 * w +: 3] = {3{pwin[w]}};
    end
  end

  always_comb begin
    job = '0;
    job_valid = 1'b0;
    if (single_path) begin
      job.ctx.pair    = 1'b0;
      job.ctx.ds_hist = ds_hist;
      job.ctx.c1      = channel;
      job.ctx.bin1    = bin_of(SUM_W'(energy));
      job.mask        = single_mask;
      job_valid       = accept && single_ok;
    end else begin
      job.ctx.pair = 1'b1;
      job.ctx.c1   = p1_ch;
      job.ctx.c2   = p2_ch;
      job.ctx.bin1 = bin_of(SUM_W'(p1_e));
      job.ctx.bin2 = bin_of(SUM_W'(p2_e));
      job.ctx.bin3 = bin_of(psum);
      job.mask     = pair_mask;
      job_valid    = accept && pair_path && last_channel && pair_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_count          <= '0;
      first_hit_channel  <= '0;
      first_hit_energy   <= '0;
      first_hit_dataset  <= '0;
      second_hit_channel <= '0;
      second_hit_energy  <= '0;
      second_hit_dataset <= '0;
    end else if (accept) begin
      if (last_channel) begin
        hit_count          <= '0;
        first_hit_channel  <= '0;
        first_hit_energy   <= '0;
        first_hit_dataset  <= '0;
        second_hit_channel <= '0;
        second_hit_energy  <= '0;
        second_hit_dataset <= '0;
      end else if (pair_path && counted) begin
        hit_count <= hit_count_next;
        if (hit_count == 2'd0) begin
          first_hit_channel <= channel;
          first_hit_energy  <= energy;
          first_hit_dataset <= dataset;
        end
        if (hit_count == 2'd1) begin
          second_hit_channel <= channel;
          second_hit_energy  <= energy;
          second_hit_dataset <= dataset;
        end
      end
    end
  end

endmodule

// ===== src/dewc_job_queue.sv =====
// short job queue between the front and back parts
module dewc_job_queue import dewc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  job_t wr_job,
  output logic full,
  input  logic rd_en,
  output logic rd_valid,
  output job_t rd_job
);

  job_t                  q [JOBQ_DEPTH];
  logic [JOBQ_PTR_W-1:0] wr_ptr;
  logic [JOBQ_PTR_W-1:0] rd_ptr;
  logic [JOBQ_CNT_W-1:0] count;
  logic                  do_wr;
  logic                  do_rd;

  assign full     = count == JOBQ_CNT_W'(JOBQ_DEPTH);
  assign rd_valid = count != '0;
  assign rd_job   = q[rd_ptr];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      q[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == JOBQ_PTR_W'(JOBQ_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == JOBQ_PTR_W'(JOBQ_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== src/dewc_back.sv =====
// back part: walks the fill slots of each job and emits one record a cycle while its output is free or popped
module dewc_back import dewc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              job_valid,
  input  job_t              job,
  output logic              job_pop,
  output logic              empty,
  input  logic              pop,
  output logic [HIST_W-1:0] histogram,
  output logic [BIN_W-1:0]  bin_x,
  output logic [BIN_W-1:0]  bin_y,
  output logic              last_fill
);

  fill_ctx_t         cur_ctx;
  slot_mask_t        cur_mask;
  slot_mask_t        rest;
  logic              busy;
  logic              out_valid;
  logic              out_free;
  logic              emit;
  logic              load;
  logic [SLOT_W-1:0] slot;
  logic [HIST_W-1:0] f_hist;
  logic [BIN_W-1:0]  f_x;
  logic [BIN_W-1:0]  f_y;

  assign busy     = cur_mask != '0;
  assign out_free = !out_valid || pop;
  assign emit     = busy && out_free;
  // drop the lowest pending slot
  assign rest     = cur_mask & (cur_mask - 1'b1);
  assign load     = job_valid && (!busy || (emit && rest == '0));
  assign job_pop  = load;
  assign empty    = !out_valid;

  always_comb begin
    slot = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (cur_mask[i]) begin
        slot = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    f_hist = H_CHAN_SPEC;
    f_x    = '0;
    f_y    = '0;
    if (!cur_ctx.pair) begin
      if (slot == SLOT_W'(0)) begin
        f_hist = H_CHAN_SPEC;
        f_x    = cur_ctx.bin1;
        f_y    = BIN_W'(cur_ctx.c1);
      end else if (slot == SLOT_W'(1)) begin
        f_hist = cur_ctx.ds_hist;
        f_x    = cur_ctx.bin1;
      end else begin
        f_hist = H_WIN_SINGLE + HIST_W'(slot - SLOT_W'(SGL_WIN0));
        f_x    = BIN_W'(cur_ctx.c1);
      end
    end else begin
      for (int w = 0; w < WINDOWS; w++) begin
        if (slot == SLOT_W'(PAIR_FIXED + 3 * w)) begin
          f_hist = H_PAIR_CC + HIST_W'(w);
          f_x    = BIN_W'(cur_ctx.c1);
          f_y    = BIN_W'(cur_ctx.c2);
        end
        if (slot == SLOT_W'(PAIR_FIXED + 3 * w + 1)) begin
          f_hist = H_PAIR_CH + HIST_W'(w);
          f_x    = BIN_W'(cur_ctx.c1);
        end
        if (slot == SLOT_W'(PAIR_FIXED + 3 * w + 2)) begin
          f_hist = H_PAIR_CH + HIST_W'(w);
          f_x    = BIN_W'(cur_ctx.c2);
        end
      end
      if (slot == SLOT_W'(0)) begin
        f_hist = H_PAIR_2D;
        f_x    = cur_ctx.bin1;
        f_y    = cur_ctx.bin2;
      end else if (slot == SLOT_W'(1)) begin
        f_hist = H_PAIR_SUM;
        f_x    = cur_ctx.bin3;
      end else if (slot == SLOT_W'(2)) begin
        f_hist = H_PAIR_E;
        f_x    = cur_ctx.bin1;
      end else if (slot == SLOT_W'(3)) begin
        f_hist = H_PAIR_E;
        f_x    = cur_ctx.bin2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur_ctx <= job.ctx;
    end
    if (emit) begin
      histogram <= f_hist;
      bin_x     <= f_x;
      bin_y     <= f_y;
      last_fill <= rest == '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_mask  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        cur_mask <= job.mask;
      end else if (emit) begin
        cur_mask <= rest;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== src/detector_event_window_classifier.sv =====
// Detector event window classifier: takes one channel of a detector event per push and
// returns histogram-fill records through a result queue. The front part accepts one item
// per cycle whenever its two-entry job queue has room; items that cause no fill write no
// job. The back part emits one record per cycle while its result register is free or
// popped, so an item that causes n fills (up to four for a single hit, up to ten at
// the end of a two-hit event) yields n records; the sustained rate is set by that output.
// Each record passes through the job queue and the back part's current-job registers to
// the registered result ports. Configuration writes are always ready and are registered.
module detector_event_window_classifier import dewc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic [MULT_W-1:0]    multiplicity,
  input  logic                 vetoed,
  input  logic [CHAN_W-1:0]    channel,
  input  logic [ENERGY_W-1:0]  energy,
  input  logic signed [DS_W-1:0] dataset,
  input  logic                 last_channel,
  output logic                 empty,
  input  logic                 pop,
  output logic [HIST_W-1:0]    histogram,
  output logic [BIN_W-1:0]     bin_x,
  output logic [BIN_W-1:0]     bin_y,
  output logic                 last_fill,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic                 cfg_data
);

  cfg_t cfg;
  logic accept;
  logic fe_job_valid;
  job_t fe_job;
  logic q_valid;
  job_t q_job;
  logic q_pop;

  assign cfg_ready = 1'b1;
  assign accept    = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.apply_veto           <= 1'b0;
      cfg.include_natural_coax <= 1'b0;
      cfg.pairs_enabled        <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_APPLY_VETO:    cfg.apply_veto           <= cfg_data;
        CFG_INCLUDE_NAT:   cfg.include_natural_coax <= cfg_data;
        CFG_PAIRS_ENABLED: cfg.pairs_enabled        <= cfg_data;
        default: ;
      endcase
    end
  end

  dewc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .accept       (accept),
    .multiplicity (multiplicity),
    .vetoed       (vetoed),
    .channel      (channel),
    .energy       (energy),
    .dataset      (DS_W'(dataset)),
    .last_channel (last_channel),
    .job_valid    (fe_job_valid),
    .job          (fe_job)
  );

  dewc_job_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (fe_job_valid),
    .wr_job   (fe_job),
    .full     (full),
    .rd_en    (q_pop),
    .rd_valid (q_valid),
    .rd_job   (q_job)
  );

  dewc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (q_valid),
    .job       (q_job),
    .job_pop   (q_pop),
    .empty     (empty),
    .pop       (pop),
    .histogram (histogram),
    .bin_x     (bin_x),
    .bin_y     (bin_y),
    .last_fill (last_fill)
  );

endmodule

// ===== verif/testbench.sv =====
// self-checking testbench for the detector event window classifier
`timescale 1ns / 1ps

module testbench;
  import dewc_pkg::*;

  // one keV in energy units, and the anticoincidence marker energy
  localparam int UNIT = 1 << FRACTION_BITS;
  localparam logic [ENERGY_W-1:0] MARKER_E = ENERGY_W'(MARKER_KEV << FRACTION_BITS);
  // a valid dataset code that belongs to no dataset class
  localparam logic [DS_W-1:0] DS_SPARE = 4'd7;
  localparam logic [CFG_IDX_W-1:0] REG_ORDER [3] = '{CFG_APPLY_VETO, CFG_INCLUDE_NAT,
                                                     CFG_PAIRS_ENABLED};

  typedef struct packed {
    logic [MULT_W-1:0]   mult;
    logic                vetoed;
    logic [CHAN_W-1:0]   channel;
    logic [ENERGY_W-1:0] energy;
    logic [DS_W-1:0]     dataset;
    logic                last;
  } det_item_t;

  typedef struct packed {
    logic [HIST_W-1:0] hist;
    logic [BIN_W-1:0]  bx;
    logic [BIN_W-1:0]  by;
    logic              last_fill;
  } fill_rec_t;

  class fill_scoreboard;
    fill_rec_t want_q[$];
    int mismatches;
    int fills_seen;
    int pairs_filled;
    bit veto_on;
    bit nat_on;
    bit pairs_on;
    logic [1:0]          hits;
    logic [CHAN_W-1:0]   ch_a, ch_b;
    logic [ENERGY_W-1:0] e_a, e_b;
    logic [DS_W-1:0]     ds_a, ds_b;

    function new();
      veto_on = 1'b0;
      nat_on = 1'b0;
      pairs_on = 1'b1;
      clear_hits();
    endfunction

    function void clear_hits();
      hits = '0;
      ch_a = '0;
      ch_b = '0;
      e_a = '0;
      e_b = '0;
      ds_a = '0;
      ds_b = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, bit val);
      case (idx)
        CFG_APPLY_VETO:    veto_on = val;
        CFG_INCLUDE_NAT:   nat_on = val;
        CFG_PAIRS_ENABLED: pairs_on = val;
        default: ;
      endcase
    endfunction

    function logic [BIN_W-1:0] kev_bin(logic [SUM_W-1:0] e);
      logic [SUM_W-1:0] b;
      b = e >> FRACTION_BITS;
      if (b >= SPECTRUM_BINS) return BIN_W'(SPECTRUM_BINS);
      return b[BIN_W-1:0];
    endfunction

    function bit in_range(logic [SUM_W-1:0] e, logic [31:0] lo, logic [31:0] hi);
      return (32'(e) >= (lo << FRACTION_BITS)) && (32'(e) < (hi << FRACTION_BITS));
    endfunction

    function bit accepted_ds(logic [DS_W-1:0] d);
      return d == DS_BEGE_A || d == DS_ENR_COAX || d == DS_BEGE_B ||
             (d == DS_NAT_COAX && nat_on);
    endfunction

    function void add_fill(logic [HIST_W-1:0] h, logic [BIN_W-1:0] x, logic [BIN_W-1:0] y);
      fill_rec_t r;
      r.hist = h;
      r.bx = x;
      r.by = y;
      r.last_fill = 1'b0;
      want_q.insert(want_q.size(), r);
    endfunction

    // works out the fills that one accepted item causes
    function void note_item(det_item_t it);
      int n_prior;
      bit live;
      logic [CHAN_W-1:0] c1, c2;
      logic [ENERGY_W-1:0] e1, e2;
      logic [SUM_W-1:0] total;
      n_prior = want_q.size();
      live = !(veto_on && it.vetoed) && (it.channel < CHANNELS);
      if (live && it.mult == 1) begin
        if (it.dataset != DS_EXCLUDED && it.energy != 0 && it.energy < MARKER_E) begin
          add_fill(H_CHAN_SPEC, kev_bin(SUM_W'(it.energy)), BIN_W'(it.channel));
          case (it.dataset)
            DS_BEGE_A, DS_BEGE_B: add_fill(H_BEGE_SPEC, kev_bin(SUM_W'(it.energy)), '0);
            DS_ENR_COAX:          add_fill(H_COAX_SPEC, kev_bin(SUM_W'(it.energy)), '0);
            DS_NAT_COAX:          add_fill(H_NAT_SPEC, kev_bin(SUM_W'(it.energy)), '0);
            default: ;
          endcase
          for (int w = 0; w < WINDOWS; w++) begin
            if (in_range(SUM_W'(it.energy), SINGLE_LO[w], SINGLE_HI[w]))
              add_fill(HIST_W'(H_WIN_SINGLE + w), BIN_W'(it.channel), '0);
          end
        end
      end else if (live && it.mult == 2 && pairs_on) begin
        if (it.dataset != DS_EXCLUDED && it.energy != 0) begin
          if (hits == 0) begin
            ch_a = it.channel;
            e_a = it.energy;
            ds_a = it.dataset;
          end else if (hits == 1) begin
            ch_b = it.channel;
            e_b = it.energy;
            ds_b = it.dataset;
          end
          if (hits != 2'd3) hits = hits + 1'b1;
        end
        if (it.last && hits == 2) begin
          // lower channel first; on a tie the earlier hit stays first
          if (ch_b < ch_a) begin
            c1 = ch_b; e1 = e_b; c2 = ch_a; e2 = e_a;
          end else begin
            c1 = ch_a; e1 = e_a; c2 = ch_b; e2 = e_b;
          end
          if (e1 != MARKER_E && e2 != MARKER_E && accepted_ds(ds_a) && accepted_ds(ds_b)) begin
            total = SUM_W'(e1) + SUM_W'(e2);
            add_fill(H_PAIR_2D, kev_bin(SUM_W'(e1)), kev_bin(SUM_W'(e2)));
            add_fill(H_PAIR_SUM, kev_bin(total), '0);
            add_fill(H_PAIR_E, kev_bin(SUM_W'(e1)), '0);
            add_fill(H_PAIR_E, kev_bin(SUM_W'(e2)), '0);
            for (int w = 0; w < WINDOWS; w++) begin
              if (in_range(total, PAIR_LO[w], PAIR_HI[w])) begin
                add_fill(HIST_W'(H_PAIR_CC + w), BIN_W'(c1), BIN_W'(c2));
                add_fill(HIST_W'(H_PAIR_CH + w), BIN_W'(c1), '0);
                add_fill(HIST_W'(H_PAIR_CH + w), BIN_W'(c2), '0);
              end
            end
            pairs_filled++;
          end
        end
      end
      if (it.last) clear_hits();
      if (want_q.size() > n_prior) want_q[want_q.size() - 1].last_fill = 1'b1;
    endfunction

    function void compare_field(string what, int want_v, logic [BIN_W-1:0] got_v);
      if (got_v !== BIN_W'(want_v)) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want_v, got_v);
      end
    endfunction

    function void check_fill(fill_rec_t got);
      fill_rec_t want;
      fills_seen++;
      if (want_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected fill: histogram %0d bin_x %0d bin_y %0d last_fill %0b",
                 $time, got.hist, got.bx, got.by, got.last_fill);
        return;
      end
      want = want_q.pop_front();
      compare_field("histogram", int'(want.hist), BIN_W'(got.hist));
      compare_field("bin_x", int'(want.bx), got.bx);
      compare_field("bin_y", int'(want.by), got.by);
      compare_field("last_fill", int'(want.last_fill), BIN_W'(got.last_fill));
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                push = 1'b0;
  logic                full;
  logic [MULT_W-1:0]   multiplicity = '0;
  logic                vetoed = 1'b0;
  logic [CHAN_W-1:0]   channel = '0;
  logic [ENERGY_W-1:0] energy = '0;
  logic [DS_W-1:0]     dataset = '0;
  logic                last_channel = 1'b0;
  logic                empty;
  logic                pop = 1'b0;
  logic [HIST_W-1:0]   histogram;
  logic [BIN_W-1:0]    bin_x;
  logic [BIN_W-1:0]    bin_y;
  logic                last_fill;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic                cfg_data = 1'b0;

  fill_scoreboard board;
  bit steady = 1'b0;
  int items_sent = 0;
  int events_sent = 0;

  detector_event_window_classifier dut (
    .clk(clk), .rst(rst),
    .push(push), .full(full),
    .multiplicity(multiplicity), .vetoed(vetoed), .channel(channel),
    .energy(energy), .dataset(dataset), .last_channel(last_channel),
    .empty(empty), .pop(pop),
    .histogram(histogram), .bin_x(bin_x), .bin_y(bin_y), .last_fill(last_fill),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // result side: check what was popped, then decide whether to pop next cycle
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) board.check_fill({histogram, bin_x, bin_y, last_fill});
      pop <= steady || ($urandom_range(0, 99) >= 15);
    end
  end

  function automatic det_item_t mk_item(int m, bit v, int c, int e, logic [DS_W-1:0] d, bit l);
    det_item_t r;
    r.mult = MULT_W'(m);
    r.vetoed = v;
    r.channel = CHAN_W'(c);
    r.energy = ENERGY_W'(e);
    r.dataset = d;
    r.last = l;
    return r;
  endfunction

  function automatic logic [DS_W-1:0] good_ds();
    case ($urandom_range(0, 3))
      0: return DS_BEGE_A;
      1: return DS_ENR_COAX;
      2: return DS_BEGE_B;
      default: return DS_NAT_COAX;
    endcase
  endfunction

  function automatic logic [DS_W-1:0] rand_ds();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return good_ds();
    if (r == 7) return DS_EXCLUDED;
    return DS_W'($urandom_range(0, 7));
  endfunction

  function automatic logic [ENERGY_W-1:0] rand_energy();
    int w;
    logic [31:0] k;
    case ($urandom_range(0, 7))
      0, 1, 2: begin
        // straddle a single-hit window edge
        w = $urandom_range(0, WINDOWS - 1);
        k = $urandom_range(0, 1) ? SINGLE_LO[w] : SINGLE_HI[w];
        return ENERGY_W'((k << FRACTION_BITS) + $urandom_range(0, 2 * UNIT - 1) - UNIT);
      end
      3: return ENERGY_W'($urandom_range(1, 3000 * UNIT));
      4: return ENERGY_W'($urandom_range(0, (1 << ENERGY_W) - 1));
      5: return ENERGY_W'($urandom_range(7990 * UNIT, 10010 * UNIT));
      6: return MARKER_E;
      default: return ENERGY_W'($urandom_range(0, 40));
    endcase
  endfunction

  task automatic send_item(det_item_t it);
    if (!steady && $urandom_range(0, 99) < 15) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    push <= 1'b1;
    multiplicity <= it.mult;
    vetoed <= it.vetoed;
    channel <= it.channel;
    energy <= it.energy;
    dataset <= it.dataset;
    last_channel <= it.last;
    @(posedge clk);
    while (full) @(posedge clk);
    board.note_item(it);
    if (it.mult == 1 || it.mult == 2) items_sent++;
  endtask

  // wait until every expected fill is out and the block has gone quiet
  task automatic settle();
    push <= 1'b0;
    @(posedge clk);
    while (board.want_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic load_config(bit veto, bit nat, bit pairs);
    logic [2:0] vals;
    vals = {pairs, nat, veto};
    cfg_valid <= 1'b1;
    for (int i = 0; i < 3; i++) begin
      cfg_index <= REG_ORDER[i];
      cfg_data <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      board.write_reg(REG_ORDER[i], vals[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic random_event();
    det_item_t ev[$];
    int kind, n, w, m;
    bit veto;
    int ch;
    int tot, e1;
    logic [DS_W-1:0] d1, d2;
    kind = $urandom_range(0, 99);
    veto = ($urandom_range(0, 4) == 0);
    if (kind < 35) begin
      n = $urandom_range(1, 3);
      ch = $urandom_range(0, 37);
      for (int i = 0; i < n; i++) begin
        ev.insert(ev.size(), mk_item(1, veto, ch, int'(rand_energy()), rand_ds(), i == n - 1));
        ch = ch + 1;
      end
    end else if (kind < 80) begin
      // well-formed two-hit event, sum mostly near a pair window
      w = $urandom_range(0, WINDOWS - 1);
      if ($urandom_range(0, 3) != 0)
        tot = (PAIR_LO[w] * UNIT) - UNIT / 2 +
              $urandom_range(0, (PAIR_HI[w] - PAIR_LO[w]) * UNIT + UNIT);
      else
        tot = $urandom_range(2, 9000 * UNIT);
      e1 = $urandom_range(1, tot - 1);
      if ($urandom_range(0, 19) == 0) e1 = int'(MARKER_E);
      d1 = ($urandom_range(0, 9) == 0) ? rand_ds() : good_ds();
      d2 = ($urandom_range(0, 9) == 0) ? rand_ds() : good_ds();
      ch = $urandom_range(0, 38);
      ev.insert(ev.size(), mk_item(2, veto, ch, e1, d1, 1'b0));
      ev.insert(ev.size(), mk_item(2, veto, $urandom_range(ch + 1, 39),
                                   tot - (tot - e1 < 0 ? 0 : e1), d2, 1'b1));
      if (e1 == MARKER_E) ev[1].energy = ENERGY_W'($urandom_range(1, 3000 * UNIT));
    end else if (kind < 90) begin
      // broken events: wrong hit counts, mixed multiplicities
      n = $urandom_range(1, 4);
      ch = $urandom_range(0, 36);
      for (int i = 0; i < n; i++) begin
        m = ($urandom_range(0, 5) == 0) ? 1 : 2;
        ev.insert(ev.size(), mk_item(m, veto, ch, int'(rand_energy()), rand_ds(), i == n - 1));
        ch = ch + $urandom_range(0, 2);
      end
    end else begin
      ev.insert(ev.size(), mk_item($urandom_range(0, 63), 1'($urandom_range(0, 1)),
                                   $urandom_range(0, 63),
                                   $urandom_range(0, (1 << ENERGY_W) - 1), rand_ds(),
                                   1'($urandom_range(0, 1))));
    end
    foreach (ev[i]) send_item(ev[i]);
    events_sent++;
  endtask

  task automatic random_phase(int quota, bit with_calm);
    int start;
    start = items_sent;
    while (items_sent - start < quota) begin
      steady = with_calm && (items_sent - start >= quota / 3) &&
               (items_sent - start < 2 * quota / 3);
      random_event();
    end
    steady = 1'b0;
  endtask

  initial begin
    #3_000_000;
    $display("testbench NOT OK");
    $finish;
  end

  initial begin
    det_item_t plan[$];
    board = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part with reset settings: veto off, natural coax off, pairs on
    plan.insert(plan.size(), mk_item(1, 0, 0, 1521 * UNIT, DS_BEGE_A, 1));
    plan.insert(plan.size(), mk_item(1, 0, 39, 1529 * UNIT - 1, DS_ENR_COAX, 1));
    plan.insert(plan.size(), mk_item(1, 0, 5, 1457 * UNIT, DS_NAT_COAX, 1));
    plan.insert(plan.size(), mk_item(1, 1, 6, 565 * UNIT - 1, DS_BEGE_B, 1));
    plan.insert(plan.size(), mk_item(1, 0, 7, 5500 * UNIT, DS_SPARE, 1));
    plan.insert(plan.size(), mk_item(1, 0, 8, 8000 * UNIT, DS_BEGE_A, 1));
    plan.insert(plan.size(), mk_item(1, 0, 9, MARKER_E - 1, DS_BEGE_A, 1));
    plan.insert(plan.size(), mk_item(1, 0, 10, int'(MARKER_E), DS_BEGE_A, 1));
    plan.insert(plan.size(), mk_item(1, 0, 12, 1, DS_BEGE_A, 1));
    plan.insert(plan.size(), mk_item(1, 0, 13, 0, DS_BEGE_A, 1));
    plan.insert(plan.size(), mk_item(1, 0, 14, 1410 * UNIT, DS_EXCLUDED, 1));
    plan.insert(plan.size(), mk_item(1, 0, 40, 1410 * UNIT, DS_BEGE_A, 0));
    plan.insert(plan.size(), mk_item(1, 0, 63, 1575 * UNIT, DS_BEGE_A, 1));
    plan.insert(plan.size(), mk_item(0, 0, 1, 1500 * UNIT, DS_BEGE_A, 1));
    plan.insert(plan.size(), mk_item(63, 1, 2, 1500 * UNIT, DS_BEGE_A, 1));
    plan.insert(plan.size(), mk_item(1, 0, 15, 1470 * UNIT, DS_SPARE, 1));
    // pair summing into the 1525 window
    plan.insert(plan.size(), mk_item(2, 0, 3, 700 * UNIT, DS_BEGE_A, 0));
    plan.insert(plan.size(), mk_item(2, 0, 9, 821 * UNIT, DS_ENR_COAX, 1));
    // channels in descending order, overflowing second hit
    plan.insert(plan.size(), mk_item(2, 0, 20, 1000 * UNIT + 7, DS_BEGE_B, 0));
    plan.insert(plan.size(), mk_item(2, 0, 10, 9000 * UNIT, DS_BEGE_A, 1));
    // equal channels keep arrival order
    plan.insert(plan.size(), mk_item(2, 0, 12, 1200 * UNIT, DS_BEGE_A, 0));
    plan.insert(plan.size(), mk_item(2, 0, 12, 325 * UNIT, DS_ENR_COAX, 1));
    // anticoincidence marker in a pair
    plan.insert(plan.size(), mk_item(2, 0, 1, int'(MARKER_E), DS_BEGE_A, 0));
    plan.insert(plan.size(), mk_item(2, 0, 2, 500 * UNIT, DS_BEGE_A, 1));
    // natural coax not accepted yet
    plan.insert(plan.size(), mk_item(2, 0, 4, 1000 * UNIT, DS_NAT_COAX, 0));
    plan.insert(plan.size(), mk_item(2, 0, 5, 460 * UNIT, DS_BEGE_A, 1));
    // only one countable hit: zero energy and excluded dataset are skipped
    plan.insert(plan.size(), mk_item(2, 0, 6, 800 * UNIT, DS_BEGE_A, 0));
    plan.insert(plan.size(), mk_item(2, 0, 7, 0, DS_BEGE_A, 0));
    plan.insert(plan.size(), mk_item(2, 0, 8, 700 * UNIT, DS_EXCLUDED, 1));
    foreach (plan[i]) send_item(plan[i]);
    settle();

    load_config(1'b1, 1'b1, 1'b1);
    random_phase(110, 1'b1);
    settle();
    load_config(1'b0, 1'b0, 1'b0);
    random_phase(40, 1'b0);
    settle();
    load_config(1'b1, 1'b0, 1'b1);
    random_phase(80, 1'b0);
    settle();
    load_config(1'b0, 1'b1, 1'b1);
    random_phase(100, 1'b0);
    settle();

    $display("covered %0d single/pair items in %0d events across five register settings",
             items_sent, events_sent);
    $display("checked %0d fill records, %0d pair events filled", board.fills_seen,
             board.pairs_filled);
    if (board.mismatches == 0 && board.want_q.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/dewc_pkg.sv
src/dewc_front.sv
src/dewc_job_queue.sv
src/dewc_back.sv
src/detector_event_window_classifier.sv
verif/testbench.sv
